/* design/assert_macros.svh */
// Assertion macros used by the checker file of the token scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define CST_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("token scanner assertion failed");

// Checked on every edge, reset included.
`define CST_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("token scanner assertion failed");

`endif

/* design/cst_pkg.sv */
// Types and constants of the C subset token scanner.
package cst_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_IDENT   = 3'd1,
      MODE_NUMBER  = 3'd2,
      MODE_SLASH   = 3'd3,
      MODE_COMMENT = 3'd4,
      MODE_STAR    = 3'd5
   } scan_mode_type;

   typedef enum logic [3:0] {
      TT_LPAREN = 4'd0,
      TT_RPAREN = 4'd1,
      TT_LBRACE = 4'd2,
      TT_RBRACE = 4'd3,
      TT_SEMI   = 4'd4,
      TT_IDENT  = 4'd5,
      TT_INT    = 4'd6,
      TT_RETURN = 4'd7,
      TT_CONST  = 4'd8,
      TT_EOF    = 4'd9
   } tok_type_type;

   typedef enum logic {
      KIND_BYTE = 1'b0,
      KIND_END  = 1'b1
   } item_kind_type;

   typedef struct packed {
      tok_type_type token_type;
      logic [15:0]  token_line;
      logic [15:0]  token_column;
      logic [7:0]   lexeme_length;
      logic [31:0]  constant_value;
      logic         last_of_run;
   } rsp_word_type;

   localparam logic [7:0]  CHAR_LPAREN     = 8'h28;
   localparam logic [7:0]  CHAR_RPAREN     = 8'h29;
   localparam logic [7:0]  CHAR_LBRACE     = 8'h7B;
   localparam logic [7:0]  CHAR_RBRACE     = 8'h7D;
   localparam logic [7:0]  CHAR_SEMI       = 8'h3B;
   localparam logic [7:0]  CHAR_SLASH      = 8'h2F;
   localparam logic [7:0]  CHAR_STAR       = 8'h2A;
   localparam logic [7:0]  CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0]  CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0]  CHAR_ZERO       = 8'h30;
   localparam logic [7:0]  CHAR_NINE       = 8'h39;
   localparam logic [7:0]  CHAR_LOWER_A    = 8'h61;
   localparam logic [7:0]  CHAR_LOWER_Z    = 8'h7A;
   localparam logic [7:0]  CHAR_UPPER_A    = 8'h41;
   localparam logic [7:0]  CHAR_UPPER_Z    = 8'h5A;

   localparam int          PREFIX_DEPTH    = 6;
   localparam logic [7:0]  KW_INT_LEN      = 8'd3;
   localparam logic [7:0]  KW_RETURN_LEN   = 8'd6;
   localparam logic [23:0] KW_INT          = "int";
   localparam logic [47:0] KW_RETURN       = "return";

endpackage

/* design/cst_if.sv */
// Valid/ready channel interfaces for source bytes and tokens.
interface cst_req_if;
   import cst_pkg::*;

   logic          valid;
   logic          ready;
   item_kind_type kind;
   logic [7:0]    char_byte;

   modport source (output valid, output kind, output char_byte, input ready);
   modport sink (input valid, input kind, input char_byte, output ready);
   modport monitor (input valid, input kind, input char_byte, input ready);
endinterface

interface cst_rsp_if;
   import cst_pkg::*;

   logic         valid;
   logic         ready;
   tok_type_type token_type;
   logic [15:0]  token_line;
   logic [15:0]  token_column;
   logic [7:0]   lexeme_length;
   logic [31:0]  constant_value;
   logic         last_of_run;

   modport source (output valid, output token_type, output token_line, output token_column,
                   output lexeme_length, output constant_value, output last_of_run,
                   input ready);
   modport sink (input valid, input token_type, input token_line, input token_column,
                 input lexeme_length, input constant_value, input last_of_run,
                 output ready);
   modport monitor (input valid, input token_type, input token_line, input token_column,
                    input lexeme_length, input constant_value, input last_of_run,
                    input ready);
endinterface

/* design/c_subset_token_scanner_unit.sv */
// Streaming tokenizer for a small C subset: source bytes in, tokens out.
//
// Takes one source byte or end marker per cycle while req ready is high. Each word is
// classified combinationally and the scanner state registered; the zero, one or two
// tokens it yields are written into a four-entry result queue, from which one token
// leaves per cycle while rsp ready is high. req ready stays high while the queue has at
// least two free slots, so with the output side taking a token every cycle the block
// sustains one input word per clock; words that yield two tokens (a pending token ended
// by a punctuator, or a flush before end-of-file) are bounded by the single token per
// cycle of the output port. After the end marker the scanner is back in its reset state.
module c_subset_token_scanner_unit (
   input logic       clock,
   input logic       reset,
   cst_req_if.sink   req_if,
   cst_rsp_if.source rsp_if
);
   import cst_pkg::*;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ||
             ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   // scanner state
   scan_mode_type mode_ff, mode_in;
   logic [15:0]   line_ff, line_in;
   logic [15:0]   col_ff, col_in;
   logic [15:0]   start_col_ff, start_col_in;
   logic [7:0]    len_ff, len_in;
   logic [31:0]   acc_ff, acc_in;
   logic [7:0]    prefix_ff [PREFIX_DEPTH];
   logic [7:0]    prefix_in [PREFIX_DEPTH];

   // result queue
   rsp_word_type       queue_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   logic         req_fire, rsp_fire;
   logic [7:0]   c;
   logic         ident_char;
   logic [3:0]   digit;
   logic [35:0]  acc_x10;
   logic [31:0]  acc_next;
   logic [15:0]  line_inc, col_inc;
   logic [7:0]   len_inc;
   logic         pending;
   logic         flush_v, char_v, scan_char;
   rsp_word_type flush_tok, char_tok, eof_tok, tok_a, tok_b;
   logic [1:0]   n_tok;
   tok_type_type ident_type, char_type;

   assign req_fire = req_if.valid && req_if.ready;
   assign rsp_fire = rsp_if.valid && rsp_if.ready;
   assign req_if.ready = (count_ff <= QCNT_W'(QDEPTH - 2));

   assign c          = req_if.char_byte;
   assign ident_char = is_alpha(c) || is_digit(c) || (c == CHAR_UNDERSCORE);
   assign digit      = 4'(c - CHAR_ZERO);
   assign acc_x10    = 36'({acc_ff, 3'b000}) + 36'({acc_ff, 1'b0}) + 36'(digit);
   assign acc_next   = (acc_x10[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc_x10[31:0];
   assign line_inc   = (line_ff == 16'hFFFF) ? line_ff : line_ff + 16'd1;
   assign col_inc    = (col_ff == 16'hFFFF) ? col_ff : col_ff + 16'd1;
   assign len_inc    = (len_ff == 8'hFF) ? len_ff : len_ff + 8'd1;
   assign pending    = (mode_ff == MODE_IDENT) || (mode_ff == MODE_NUMBER);

   always_comb begin
      ident_type = TT_IDENT;
      if ((len_ff == KW_INT_LEN) && ({prefix_ff[0], prefix_ff[1], prefix_ff[2]} == KW_INT)) begin
         ident_type = TT_INT;
      end else if ((len_ff == KW_RETURN_LEN) &&
                   ({prefix_ff[0], prefix_ff[1], prefix_ff[2], prefix_ff[3], prefix_ff[4],
                     prefix_ff[5]} == KW_RETURN)) begin
         ident_type = TT_RETURN;
      end
   end

   always_comb begin
      flush_tok.token_type     = (mode_ff == MODE_NUMBER) ? TT_CONST : ident_type;
      flush_tok.token_line     = line_ff;
      flush_tok.token_column   = start_col_ff;
      flush_tok.lexeme_length  = len_ff;
      flush_tok.constant_value = (mode_ff == MODE_NUMBER) ? acc_ff : 32'd0;
      flush_tok.last_of_run    = 1'b0;

      eof_tok.token_type       = TT_EOF;
      eof_tok.token_line       = line_ff;
      eof_tok.token_column     = col_ff;
      eof_tok.lexeme_length    = 8'd0;
      eof_tok.constant_value   = 32'd0;
      eof_tok.last_of_run      = 1'b0;
   end

   always_comb begin
      char_v    = 1'b1;
      char_type = TT_LPAREN;
      unique case (c)
         CHAR_LPAREN: char_type = TT_LPAREN;
         CHAR_RPAREN: char_type = TT_RPAREN;
         CHAR_LBRACE: char_type = TT_LBRACE;
         CHAR_RBRACE: char_type = TT_RBRACE;
         CHAR_SEMI:   char_type = TT_SEMI;
         default:     char_v = 1'b0;
      endcase
      char_tok.token_type     = char_type;
      char_tok.token_line     = line_ff;
      char_tok.token_column   = col_ff;
      char_tok.lexeme_length  = 8'd1;
      char_tok.constant_value = 32'd0;
      char_tok.last_of_run    = 1'b0;
   end

   // next state of the scanner and the tokens of the accepted word
   always_comb begin
      mode_in      = mode_ff;
      line_in      = line_ff;
      col_in       = col_ff;
      start_col_in = start_col_ff;
      len_in       = len_ff;
      acc_in       = acc_ff;
      for (int i = 0; i < PREFIX_DEPTH; i++) begin
         prefix_in[i] = prefix_ff[i];
      end
      flush_v   = 1'b0;
      scan_char = 1'b0;
      tok_a     = eof_tok;
      tok_b     = eof_tok;
      n_tok     = 2'd0;

      if (req_fire) begin
         if (req_if.kind == KIND_END) begin
            if (pending) begin
               tok_a = flush_tok;
               tok_b = eof_tok;
               n_tok = 2'd2;
            end else begin
               tok_a = eof_tok;
               n_tok = 2'd1;
            end
            mode_in      = MODE_IDLE;
            line_in      = 16'd1;
            col_in       = 16'd1;
            start_col_in = 16'd1;
            len_in       = 8'd0;
            acc_in       = 32'd0;
            for (int i = 0; i < PREFIX_DEPTH; i++) begin
               prefix_in[i] = 8'd0;
            end
         end else begin
            unique case (mode_ff)
               MODE_COMMENT: begin
                  if (c == CHAR_STAR) mode_in = MODE_STAR;
               end
               MODE_STAR: begin
                  if (c == CHAR_SLASH) mode_in = MODE_IDLE;
                  else if (c != CHAR_STAR) mode_in = MODE_COMMENT;
               end
               MODE_IDENT: begin
                  if (ident_char) begin
                     for (int i = 0; i < PREFIX_DEPTH; i++) begin
                        if (len_ff == 8'(i)) prefix_in[i] = c;
                     end
                     len_in = len_inc;
                  end else begin
                     flush_v   = 1'b1;
                     scan_char = 1'b1;
                  end
               end
               MODE_NUMBER: begin
                  if (is_digit(c)) begin
                     acc_in = acc_next;
                     len_in = len_inc;
                  end else begin
                     flush_v   = 1'b1;
                     scan_char = 1'b1;
                  end
               end
               MODE_SLASH: begin
                  if (c == CHAR_STAR) mode_in = MODE_COMMENT;
                  else scan_char = 1'b1;
               end
               MODE_IDLE: scan_char = 1'b1;
               default:   scan_char = 1'b1;
            endcase

            if (scan_char) begin
               mode_in = MODE_IDLE;
               if (is_alpha(c) || (c == CHAR_UNDERSCORE)) begin
                  mode_in      = MODE_IDENT;
                  start_col_in = col_ff;
                  len_in       = 8'd1;
                  for (int i = 1; i < PREFIX_DEPTH; i++) begin
                     prefix_in[i] = 8'd0;
                  end
                  prefix_in[0] = c;
               end else if (is_digit(c)) begin
                  mode_in      = MODE_NUMBER;
                  start_col_in = col_ff;
                  len_in       = 8'd1;
                  acc_in       = 32'(digit);
               end else if (c == CHAR_SLASH) begin
                  mode_in = MODE_SLASH;
               end
            end

            if (flush_v && scan_char && char_v) begin
               tok_a = flush_tok;
               tok_b = char_tok;
               n_tok = 2'd2;
            end else if (flush_v) begin
               tok_a = flush_tok;
               n_tok = 2'd1;
            end else if (scan_char && char_v) begin
               tok_a = char_tok;
               n_tok = 2'd1;
            end

            if (c == CHAR_NEWLINE) begin
               line_in = line_inc;
               col_in  = 16'd1;
            end else begin
               col_in = col_inc;
            end
         end
      end

      tok_a.last_of_run = (n_tok == 2'd1);
      tok_b.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         line_ff      <= 16'd1;
         col_ff       <= 16'd1;
         start_col_ff <= 16'd1;
         len_ff       <= 8'd0;
         acc_ff       <= 32'd0;
         for (int i = 0; i < PREFIX_DEPTH; i++) begin
            prefix_ff[i] <= 8'd0;
         end
      end else begin
         mode_ff      <= mode_in;
         line_ff      <= line_in;
         col_ff       <= col_in;
         start_col_ff <= start_col_in;
         len_ff       <= len_in;
         acc_ff       <= acc_in;
         for (int i = 0; i < PREFIX_DEPTH; i++) begin
            prefix_ff[i] <= prefix_in[i];
         end
      end
   end

   // result queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(n_tok);
      rd_ptr_in = rsp_fire ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(n_tok) - QCNT_W'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_tok != 2'd0) queue_ff[wr_ptr_ff] <= tok_a;
      if (n_tok == 2'd2) queue_ff[wr_ptr_ff + QPTR_W'(1)] <= tok_b;
   end

   assign rsp_if.valid          = (count_ff != '0);
   assign rsp_if.token_type     = queue_ff[rd_ptr_ff].token_type;
   assign rsp_if.token_line     = queue_ff[rd_ptr_ff].token_line;
   assign rsp_if.token_column   = queue_ff[rd_ptr_ff].token_column;
   assign rsp_if.lexeme_length  = queue_ff[rd_ptr_ff].lexeme_length;
   assign rsp_if.constant_value = queue_ff[rd_ptr_ff].constant_value;
   assign rsp_if.last_of_run    = queue_ff[rd_ptr_ff].last_of_run;

endmodule

/* design/cst_checker.sv */
// Port-level checks on the token scanner's result channel, bound into the scanner unit.
`include "assert_macros.svh"

module cst_checker (
   input logic       clock,
   input logic       reset,
   cst_rsp_if.source rsp_if
);
   import cst_pkg::*;

   logic rsp_stall;
   assign rsp_stall = rsp_if.valid && !rsp_if.ready;

   // queue is empty straight after reset
   `CST_ASSERT_ALWAYS(a_empty_after_reset, clock, reset |=> !rsp_if.valid)

   // a stalled token stays valid and holds its type, line, column and value
   `CST_ASSERT(a_stall_holds, clock, reset, rsp_stall |=> rsp_if.valid && $stable(rsp_if.token_type) && $stable(rsp_if.token_line) && $stable(rsp_if.token_column) && $stable(rsp_if.constant_value))

   // end-of-file closes its run and carries no text
   `CST_ASSERT(a_eof_last, clock, reset, rsp_if.valid && (rsp_if.token_type == TT_EOF) |-> rsp_if.last_of_run && (rsp_if.lexeme_length == 8'd0))

   // only constants carry a value
   `CST_ASSERT(a_value_only_const, clock, reset, rsp_if.valid && (rsp_if.token_type != TT_CONST) |-> rsp_if.constant_value == 32'd0)

   // positions count from one
   `CST_ASSERT(a_position_nonzero, clock, reset, rsp_if.valid |-> (rsp_if.token_line != 16'd0) && (rsp_if.token_column != 16'd0))

endmodule

bind c_subset_token_scanner_unit cst_checker u_cst_checker (
   .clock  (clock),
   .reset  (reset),
   .rsp_if (rsp_if)
);

/* tb/sv/token_stream_checker.sv */
// Token scanner checker: predicts tokens from accepted source words and compares results.
`timescale 1ns / 100ps
module token_stream_checker (
   input  logic       clock,
   input  logic       reset,
   cst_req_if.monitor req_mon,
   cst_rsp_if.monitor rsp_mon,
   output int         fail_count,
   output int         tokens_pending,
   output int         tokens_checked,
   output int         kinds_seen
);
   import cst_pkg::*;

   scan_mode_type mode;
   logic [15:0]   line_no;
   logic [15:0]   col_no;
   logic [15:0]   tok_col;
   logic [7:0]    tok_len;
   logic [31:0]   tok_value;
   logic [7:0]    tok_chars [PREFIX_DEPTH];
   bit   [9:0]    kinds_hit;

   rsp_word_type  word_tokens[$];
   rsp_word_type  expected_tokens[$];

   function automatic bit is_letter(logic [7:0] ch);
      return (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) ||
             (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z);
   endfunction

   function automatic bit is_numeral(logic [7:0] ch);
      return ch >= CHAR_ZERO && ch <= CHAR_NINE;
   endfunction

   function automatic void clear_scanner();
      mode      = MODE_IDLE;
      line_no   = 16'd1;
      col_no    = 16'd1;
      tok_col   = 16'd1;
      tok_len   = 8'd0;
      tok_value = 32'd0;
      foreach (tok_chars[i]) tok_chars[i] = 8'd0;
   endfunction

   function automatic void push_token(tok_type_type t, logic [15:0] col, logic [7:0] len,
                                      logic [31:0] val);
      rsp_word_type w;
      w.token_type     = t;
      w.token_line     = line_no;
      w.token_column   = col;
      w.lexeme_length  = len;
      w.constant_value = val;
      w.last_of_run    = 1'b0;
      word_tokens.insert(word_tokens.size(), w);
   endfunction

   function automatic void close_token();
      tok_type_type t;
      if (mode == MODE_IDENT) begin
         t = TT_IDENT;
         if (tok_len == KW_INT_LEN &&
             {tok_chars[0], tok_chars[1], tok_chars[2]} == KW_INT) begin
            t = TT_INT;
         end else if (tok_len == KW_RETURN_LEN &&
                      {tok_chars[0], tok_chars[1], tok_chars[2], tok_chars[3],
                       tok_chars[4], tok_chars[5]} == KW_RETURN) begin
            t = TT_RETURN;
         end
         push_token(t, tok_col, tok_len, 32'd0);
      end else if (mode == MODE_NUMBER) begin
         push_token(TT_CONST, tok_col, tok_len, tok_value);
      end
      mode = MODE_IDLE;
   endfunction

   function automatic void advance_position(logic [7:0] ch);
      if (ch == CHAR_NEWLINE) begin
         if (line_no != 16'hFFFF) line_no++;
         col_no = 16'd1;
      end else if (col_no != 16'hFFFF) begin
         col_no++;
      end
   endfunction

   function automatic void start_token(scan_mode_type m, logic [7:0] ch);
      mode    = m;
      tok_col = col_no;
      tok_len = 8'd1;
      foreach (tok_chars[i]) tok_chars[i] = 8'd0;
      tok_chars[0] = ch;
      tok_value = 32'(ch - CHAR_ZERO);
   endfunction

   function automatic void scan_source_word(item_kind_type kind, logic [7:0] ch);
      logic [35:0] wide;
      bit          consumed;
      word_tokens.delete();
      consumed = 1'b0;
      if (kind == KIND_END) begin
         close_token();
         push_token(TT_EOF, col_no, 8'd0, 32'd0);
         clear_scanner();
      end else begin
         case (mode)
            MODE_COMMENT: begin
               if (ch == CHAR_STAR) mode = MODE_STAR;
               consumed = 1'b1;
            end
            MODE_STAR: begin
               if (ch == CHAR_SLASH) mode = MODE_IDLE;
               else if (ch != CHAR_STAR) mode = MODE_COMMENT;
               consumed = 1'b1;
            end
            MODE_IDENT: begin
               if (is_letter(ch) || is_numeral(ch) || ch == CHAR_UNDERSCORE) begin
                  if (tok_len < PREFIX_DEPTH) tok_chars[tok_len] = ch;
                  if (tok_len != 8'hFF) tok_len++;
                  consumed = 1'b1;
               end else begin
                  close_token();
               end
            end
            MODE_NUMBER: begin
               if (is_numeral(ch)) begin
                  wide = 36'(tok_value) * 36'd10 + 36'(ch - CHAR_ZERO);
                  tok_value = (wide > 36'hFFFFFFFF) ? 32'hFFFFFFFF : wide[31:0];
                  if (tok_len != 8'hFF) tok_len++;
                  consumed = 1'b1;
               end else begin
                  close_token();
               end
            end
            MODE_SLASH: begin
               if (ch == CHAR_STAR) begin
                  mode = MODE_COMMENT;
                  consumed = 1'b1;
               end else begin
                  mode = MODE_IDLE;
               end
            end
            default: mode = MODE_IDLE;
         endcase
         if (!consumed) begin
            case (ch)
               CHAR_LPAREN: push_token(TT_LPAREN, col_no, 8'd1, 32'd0);
               CHAR_RPAREN: push_token(TT_RPAREN, col_no, 8'd1, 32'd0);
               CHAR_LBRACE: push_token(TT_LBRACE, col_no, 8'd1, 32'd0);
               CHAR_RBRACE: push_token(TT_RBRACE, col_no, 8'd1, 32'd0);
               CHAR_SEMI:   push_token(TT_SEMI, col_no, 8'd1, 32'd0);
               CHAR_SLASH:  mode = MODE_SLASH;
               default: begin
                  if (is_letter(ch) || ch == CHAR_UNDERSCORE) start_token(MODE_IDENT, ch);
                  else if (is_numeral(ch)) start_token(MODE_NUMBER, ch);
               end
            endcase
         end
         advance_position(ch);
      end
      if (word_tokens.size() > 0) word_tokens[$].last_of_run = 1'b1;
      foreach (word_tokens[i]) expected_tokens.insert(expected_tokens.size(), word_tokens[i]);
   endfunction

   function automatic void check_token();
      rsp_word_type want;
      rsp_word_type got;
      got = '{rsp_mon.token_type, rsp_mon.token_line, rsp_mon.token_column,
              rsp_mon.lexeme_length, rsp_mon.constant_value, rsp_mon.last_of_run};
      tokens_checked++;
      if (expected_tokens.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("unexpected token: type %0d line %0d col %0d len %0d value %0d last %0b",
                     got.token_type, got.token_line, got.token_column, got.lexeme_length,
                     got.constant_value, got.last_of_run);
         return;
      end
      want = expected_tokens.pop_front();
      if (got.token_type !== want.token_type || got.token_line !== want.token_line ||
          got.token_column !== want.token_column ||
          got.lexeme_length !== want.lexeme_length ||
          got.constant_value !== want.constant_value ||
          got.last_of_run !== want.last_of_run) begin
         fail_count++;
         if (fail_count <= 10) begin
            $display("token %0d mismatch at %0t", tokens_checked, $realtime);
            $display("  expected type %0d line %0d col %0d len %0d value %0d last %0b",
                     want.token_type, want.token_line, want.token_column,
                     want.lexeme_length, want.constant_value, want.last_of_run);
            $display("  actual   type %0d line %0d col %0d len %0d value %0d last %0b",
                     got.token_type, got.token_line, got.token_column, got.lexeme_length,
                     got.constant_value, got.last_of_run);
         end
      end else begin
         kinds_hit[want.token_type] = 1'b1;
      end
   endfunction

   initial clear_scanner();

   always @(posedge clock) begin
      if (reset) begin
         clear_scanner();
         expected_tokens.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) scan_source_word(req_mon.kind, req_mon.char_byte);
         if (rsp_mon.valid && rsp_mon.ready) check_token();
      end
      tokens_pending = expected_tokens.size();
      kinds_seen     = $countones(kinds_hit);
   end

endmodule

/* tb/sv/c_subset_token_scanner_unit_tb.sv */
// Token scanner testbench top: clock, reset, source stimulus, output stalls and verdict.
`timescale 1ns / 100ps
module c_subset_token_scanner_unit_tb;
   import cst_pkg::*;

   localparam int         STALL_LIMIT = 2000;
   localparam int         HOLD_CYCLES = 300;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam string      LEAD_CHARS  =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
   localparam string      IDENT_CHARS =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
   localparam string      DIGIT_CHARS = "0123456789";
   localparam string      JUNK_CHARS  = "#+-=\"'!@$%&|\\~`.,<>?[]:";

   logic clock = 1'b0;
   logic reset;
   bit   calm;
   bit   long_hold;
   int   words_sent;
   int   sources;
   int   fail_count;
   int   tokens_pending;
   int   tokens_checked;
   int   kinds_seen;

   string near_words[7] = '{"in", "intx", "retur", "returnx", "Int", "_int", "int0"};

   cst_req_if req_if ();
   cst_rsp_if rsp_if ();

   c_subset_token_scanner_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   token_stream_checker CHECK (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .fail_count     (fail_count),
      .tokens_pending (tokens_pending),
      .tokens_checked (tokens_checked),
      .kinds_seen     (kinds_seen)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [7:0] pick_char(string set);
      return set[$urandom_range(0, set.len() - 1)];
   endfunction

   task automatic put_word(item_kind_type kind, logic [7:0] ch);
      if (!calm && $urandom_range(0, 9) == 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 9) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid     <= 1'b1;
      req_if.kind      <= kind;
      req_if.char_byte <= ch;
      do @(posedge clock); while (!req_if.ready);
      words_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) put_word(KIND_BYTE, s[i]);
   endtask

   task automatic drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (tokens_pending != 0) @(negedge clock);
   endtask

   task automatic send_random_source(int min_words);
      int start;
      int pick;
      start = words_sent;
      while (words_sent - start < min_words) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            send_text(($urandom_range(0, 1) == 0) ? "int" : "return");
            if ($urandom_range(0, 1) == 0) put_word(KIND_BYTE, CHAR_SPACE);
         end else if (pick < 30) begin
            if ($urandom_range(0, 3) == 0) begin
               send_text(near_words[$urandom_range(0, 6)]);
            end else begin
               put_word(KIND_BYTE, pick_char(LEAD_CHARS));
               repeat ($urandom_range(0, 7)) put_word(KIND_BYTE, pick_char(IDENT_CHARS));
            end
            if ($urandom_range(0, 1) == 0) put_word(KIND_BYTE, CHAR_SPACE);
         end else if (pick < 42) begin
            repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 14 : 4))
               put_word(KIND_BYTE, pick_char(DIGIT_CHARS));
            if ($urandom_range(0, 1) == 0) put_word(KIND_BYTE, CHAR_SPACE);
         end else if (pick < 62) begin
            put_word(KIND_BYTE, pick_char("(){};"));
         end else if (pick < 75) begin
            put_word(KIND_BYTE, ($urandom_range(0, 2) != 0) ? pick_char(" \n")
                                                            : 8'($urandom_range(9, 13)));
         end else if (pick < 83) begin
            send_text("/*");
            repeat ($urandom_range(0, 10))
               put_word(KIND_BYTE, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                               : pick_char("**// a\n"));
            send_text(($urandom_range(0, 2) == 0) ? "**/" : "*/");
         end else if (pick < 87) begin
            put_word(KIND_BYTE, CHAR_SLASH);
         end else if (pick < 93) begin
            put_word(KIND_BYTE, ($urandom_range(0, 1) == 0) ? 8'($urandom_range(128, 255))
                                                            : pick_char(JUNK_CHARS));
         end else begin
            put_word(KIND_BYTE, 8'($urandom_range(0, 255)));
         end
      end
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
         send_text("/*");
         repeat ($urandom_range(0, 5)) put_word(KIND_BYTE, 8'($urandom_range(0, 255)));
      end else if (pick < 3) begin
         put_word(KIND_BYTE, CHAR_SLASH);
      end
      put_word(KIND_END, 8'($urandom_range(0, 255)));
      sources++;
   endtask

   // over-long identifier and constant
   task automatic send_saturating_source();
      send_text("return");
      repeat (294) put_word(KIND_BYTE, pick_char(IDENT_CHARS));
      put_word(KIND_BYTE, CHAR_SPACE);
      repeat (300) put_word(KIND_BYTE, pick_char(DIGIT_CHARS));
      send_text("int;");
      put_word(KIND_END, 8'($urandom_range(0, 255)));
      sources++;
   endtask

   initial begin : receiver
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            long_hold = 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 9) - 1) @(negedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
         else quiet++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      req_if.valid     = 1'b0;
      req_if.kind      = KIND_BYTE;
      req_if.char_byte = 8'd0;
      reset            = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_text("int 9a(){\nreturn;}");
      put_word(KIND_BYTE, CHAR_SLASH);
      put_word(KIND_BYTE, 8'hFF);
      put_word(KIND_END, 8'h00);
      send_text("/*/");
      put_word(KIND_BYTE, 8'h00);
      send_text("*//");
      put_word(KIND_END, 8'hFF);
      sources = 2;
      drain();

      long_hold = 1'b1;
      repeat (40) put_word(KIND_BYTE, CHAR_SEMI);
      put_word(KIND_END, 8'h00);
      sources++;
      drain();

      while (words_sent < 600) send_random_source($urandom_range(10, 80));
      drain();
      send_saturating_source();

      calm = 1'b1;
      repeat (4) send_random_source($urandom_range(20, 60));
      drain();
      repeat (20) @(posedge clock);

      $display("%0d source words in %0d sources: comments, stray and invalid bytes,",
               words_sent, sources);
      $display("over-long names and numbers, a long output stall; %0d tokens of %0d kinds",
               tokens_checked, kinds_seen);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+design
design/cst_pkg.sv
design/cst_if.sv
design/c_subset_token_scanner_unit.sv
design/cst_checker.sv
tb/sv/token_stream_checker.sv
tb/sv/c_subset_token_scanner_unit_tb.sv
